@@ sv/tpe_pkg.sv @@
// shared types, constants and tables of the pwm expander refresher
package tpe_pkg;

	localparam int CHANNELS  = 64;
	localparam int STEPS     = 32;
	localparam int EXPANDERS = CHANNELS / 16;
	localparam int BYTES     = EXPANDERS * 4;
	localparam int ROWS      = (CHANNELS + 7) / 8;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int CNT_W     = $clog2(BYTES);
	localparam int STEP_W    = (STEPS > 1) ? $clog2(STEPS) : 1;

	localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

	// item kinds
	localparam logic [1:0] KIND_WRITE   = 2'd0;
	localparam logic [1:0] KIND_REFRESH = 2'd1;
	localparam logic [1:0] KIND_SETUP   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_BASE_ADDR = 2'd0;
	localparam logic [1:0] REG_OUT_REG   = 2'd1;
	localparam logic [1:0] REG_DIR_REG   = 2'd2;

	localparam logic [6:0] BASE_ADDR_RST = 7'h20;
	localparam logic [7:0] OUT_REG_RST   = 8'h12;
	localparam logic [7:0] DIR_REG_RST   = 8'h00;

	localparam logic [7:0] TH_TAB [32] = '{
		8'h07, 8'h0F, 8'h17, 8'h1E, 8'h26, 8'h2E, 8'h36, 8'h3C,
		8'h45, 8'h4C, 8'h55, 8'h5B, 8'h64, 8'h6B, 8'h74, 8'h7A,
		8'h83, 8'h8A, 8'h93, 8'h99, 8'hA2, 8'hA9, 8'hB2, 8'hB8,
		8'hC1, 8'hC8, 8'hD1, 8'hD7, 8'hE0, 8'hE7, 8'hF0, 8'hF7
	};

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] channel_index;
		logic [7:0] level;
	} in_item_t;

	typedef struct packed {
		logic [7:0] bus_byte;
		logic       start_before;
		logic       stop_after;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [1:0] op;
		logic [5:0] ch;
		logic [7:0] level;
	} q_entry_t;

	typedef struct packed {
		logic [6:0] base_addr;
		logic [7:0] out_reg;
		logic [7:0] dir_reg;
	} cfg_t;

endpackage

@@ sv/tpe_front.sv @@
// front end: accepts items, drops ignored ones, queues the rest
module tpe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  tpe_pkg::in_item_t in_data,
	output logic              q_valid,
	output tpe_pkg::q_entry_t q_entry,
	input  logic              q_pop
);

	tpe_pkg::q_entry_t ent_q [2];
	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       accept;
	logic       keep;
	logic       push;

	assign in_stall = (count_q == 2'd2);
	assign accept   = in_valid && !in_stall;
	assign keep     = (in_data.kind inside {tpe_pkg::KIND_REFRESH, tpe_pkg::KIND_SETUP}) ||
		((in_data.kind == tpe_pkg::KIND_WRITE) &&
		 ({1'b0, in_data.channel_index} < tpe_pkg::CH_LIMIT));
	assign push     = accept && keep;
	assign q_valid  = (count_q != 2'd0);
	assign q_entry  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !q_pop)
				count_q <= count_q + 2'd1;
			else if (!push && q_pop)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q].op    <= in_data.kind;
			ent_q[wr_ptr_q].ch    <= in_data.channel_index;
			ent_q[wr_ptr_q].level <= in_data.level;
		end
	end

endmodule

@@ sv/tpe_back.sv @@
// back end: level store, byte sequencer and output register
module tpe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tpe_pkg::cfg_t      cfg,
	input  logic               q_valid,
	input  tpe_pkg::q_entry_t  q_entry,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output tpe_pkg::out_item_t out_data
);

	localparam logic [1:0] POS_ADDR = 2'd0;
	localparam logic [1:0] POS_REG  = 2'd1;
	localparam logic [1:0] POS_D0   = 2'd2;
	localparam logic [1:0] POS_D1   = 2'd3;
	localparam logic [tpe_pkg::CNT_W-1:0] LAST_SLOT = tpe_pkg::CNT_W'(tpe_pkg::BYTES - 1);
	localparam logic [tpe_pkg::STEP_W-1:0] LAST_STEP = tpe_pkg::STEP_W'(tpe_pkg::STEPS - 1);

	// level store
	logic [63:0] mem_q [tpe_pkg::ROWS];
	logic [7:0]  vld_q [tpe_pkg::ROWS];

	// sequencer
	logic                        busy_q;
	logic [tpe_pkg::CNT_W-1:0]   cnt_q;
	logic                        refresh_q;
	logic [7:0]                  th_q;
	logic [7:0]                  reg_q;
	logic [tpe_pkg::STEP_W-1:0]  step_q;

	// byte stage
	logic                        valid_s1;
	logic [tpe_pkg::CNT_W-1:0]   slot_s1;
	logic                        refresh_s1;
	logic [7:0]                  th_s1;
	logic [7:0]                  reg_s1;
	logic [63:0]                 rdata_s1;
	logic [7:0]                  rvld_s1;

	logic                        out_valid_q;
	tpe_pkg::out_item_t          out_data_q;

	logic                        en;
	logic                        last_slot;
	logic                        wr_en;
	logic [tpe_pkg::ROW_W-1:0]   wr_row;
	logic [2:0]                  wr_lane;
	logic [tpe_pkg::ROW_W-1:0]   rd_row;
	logic [1:0]                  pos;
	logic [6:0]                  addr;
	logic [7:0]                  packed_bits;
	logic [7:0]                  lvl;
	tpe_pkg::out_item_t          nxt;

	assign en        = !out_valid_q || !out_stall;
	assign last_slot = (cnt_q == LAST_SLOT);
	assign q_pop     = en && q_valid && (!busy_q || last_slot);
	assign wr_en     = q_pop && (q_entry.op == tpe_pkg::KIND_WRITE);
	assign wr_row    = tpe_pkg::ROW_W'(q_entry.ch >> 3);
	assign wr_lane   = q_entry.ch[2:0];
	assign rd_row    = tpe_pkg::ROW_W'({cnt_q >> 2, cnt_q[0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < tpe_pkg::ROWS; r++)
				vld_q[r] <= 8'h00;
		end else if (wr_en) begin
			vld_q[wr_row][wr_lane] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_row][{wr_lane, 3'b000} +: 8] <= q_entry.level;
		if (en) begin
			rdata_s1 <= mem_q[rd_row];
			rvld_s1  <= vld_q[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			step_q   <= '0;
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= busy_q;
			if (q_pop && (q_entry.op != tpe_pkg::KIND_WRITE)) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				if (q_entry.op == tpe_pkg::KIND_REFRESH)
					step_q <= (step_q == LAST_STEP) ? '0 : step_q + 1'b1;
			end else if (busy_q) begin
				if (last_slot)
					busy_q <= 1'b0;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (q_pop && (q_entry.op != tpe_pkg::KIND_WRITE)) begin
				refresh_q <= (q_entry.op == tpe_pkg::KIND_REFRESH);
				th_q      <= tpe_pkg::TH_TAB[5'(step_q)];
				reg_q     <= (q_entry.op == tpe_pkg::KIND_REFRESH) ? cfg.out_reg : cfg.dir_reg;
			end
			slot_s1    <= cnt_q;
			refresh_s1 <= refresh_q;
			th_s1      <= th_q;
			reg_s1     <= reg_q;
		end
	end

	// byte formation
	assign pos  = slot_s1[1:0];
	assign addr = cfg.base_addr + 7'(slot_s1 >> 2);

	always_comb begin
		packed_bits = 8'hFF;
		for (int k = 0; k < 8; k++) begin
			lvl = rvld_s1[k] ? rdata_s1[k*8 +: 8] : 8'h00;
			if (lvl > th_s1)
				packed_bits[k] = 1'b0;
		end
	end

	always_comb begin
		nxt.start_before = (pos == POS_ADDR);
		nxt.stop_after   = (pos == POS_D1);
		nxt.last         = (slot_s1 == LAST_SLOT);
		case (pos)
			POS_ADDR: nxt.bus_byte = {addr, 1'b0};
			POS_REG:  nxt.bus_byte = reg_s1;
			POS_D0,
			POS_D1:   nxt.bus_byte = refresh_s1 ? packed_bits : 8'h00;
			default:  nxt.bus_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en)
			out_data_q <= nxt;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ sv/threshold_pwm_expander_refresh.sv @@
// top level of the multichannel pwm refresher for 16-bit bus expanders
//
// in channel (in_valid, in_stall, in_data): a write item stores one channel
// level and gives no bytes; a refresh tick gives 16 bus bytes, four per
// expander (address, output register, two pin data bytes); a set-up item
// gives the same run with the direction register and zero data bytes.
// kind 3 and writes to channels past the channel count are taken and dropped.
// out channel (out_valid, out_stall, out_data): one bus byte per transfer,
// with start, stop and end-of-run marks.
// cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): always ready; the
// user must write it only while the block is idle; this is not enforced.
// the first byte of a run passes the queue, the sequencer, the byte stage
// and the output register. throughput: one byte per cycle while the receiver
// does not stall, and runs follow each other without a gap. the rate is set
// by the byte sequencer reading one 8-level row of the level store per cycle.
// a two-entry queue between front and back keeps input transfers going while
// the receiver stalls until the queue is full; a stall freezes the back end
// with its byte held. reset clears all levels (per-channel valid bits), the
// step counter and the queue, and loads the register reset values; no
// clearing pass is needed.
module threshold_pwm_expander_refresh (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tpe_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output tpe_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	tpe_pkg::cfg_t     cfg_q;
	logic              q_valid;
	tpe_pkg::q_entry_t q_entry;
	logic              q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_addr <= tpe_pkg::BASE_ADDR_RST;
			cfg_q.out_reg   <= tpe_pkg::OUT_REG_RST;
			cfg_q.dir_reg   <= tpe_pkg::DIR_REG_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tpe_pkg::REG_BASE_ADDR: cfg_q.base_addr <= cfg_data[6:0];
				tpe_pkg::REG_OUT_REG:   cfg_q.out_reg   <= cfg_data;
				tpe_pkg::REG_DIR_REG:   cfg_q.dir_reg   <= cfg_data;
				default: ;
			endcase
		end
	end

	tpe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.q_pop    (q_pop)
	);

	tpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

@@ sv/tpe_checker.sv @@
// port checker of the pwm refresher and its bind
module tpe_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input tpe_pkg::out_item_t out_data,
	input logic               cfg_ready
);

	// a stalled byte stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output byte changed");

	// end of run closes an expander transfer
	a_last_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last |-> out_data.stop_after)
		else $error("last byte without stop");

	// address bytes carry the write bit and never a stop
	a_addr_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.start_before |->
			!out_data.bus_byte[0] && !out_data.stop_after)
		else $error("bad address byte");

	// a stop is followed by a start on the next byte of a run
	a_stop_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.stop_after && !out_data.last ##1 out_valid
		|-> out_data.start_before)
		else $error("byte after stop has no start");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");

endmodule

bind threshold_pwm_expander_refresh tpe_checker u_tpe_checker (.*);

@@ tb/threshold_pwm_expander_refresh_tb.sv @@
// testbench for the pwm expander refresher: directed and random items checked byte by byte
module threshold_pwm_expander_refresh_tb;
	import tpe_pkg::*;

	localparam logic [1:0] KIND_IGNORED  = 2'd3;
	localparam int         NUM_STEPS     = 32;
	localparam int         NUM_EXPANDERS = 4;
	localparam int         SETTLE_CYCLES = 16;

	localparam logic [7:0] step_threshold [NUM_STEPS] = '{
		8'h07, 8'h0F, 8'h17, 8'h1E, 8'h26, 8'h2E, 8'h36, 8'h3C,
		8'h45, 8'h4C, 8'h55, 8'h5B, 8'h64, 8'h6B, 8'h74, 8'h7A,
		8'h83, 8'h8A, 8'h93, 8'h99, 8'hA2, 8'hA9, 8'hB2, 8'hB8,
		8'hC1, 8'hC8, 8'hD1, 8'hD7, 8'hE0, 8'hE7, 8'hF0, 8'hF7
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_stall;
	out_item_t  out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	// predicted state of the block
	logic [7:0] level_mem [64];
	logic [4:0] step_cnt;
	logic [6:0] base_addr;
	logic [7:0] out_reg;
	logic [7:0] dir_reg;

	out_item_t bytes_due [$];
	out_item_t due_byte;
	int        errors;
	int        send_idle_pct;
	int        recv_idle_pct;

	threshold_pwm_expander_refresh u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("FAIL threshold_pwm_expander_refresh");
		$finish;
	end

	function automatic logic [7:0] pack_group(input int first, input logic [7:0] th);
		logic [7:0] b;
		b = 8'hFF;
		for (int k = 0; k < 8; k++) begin
			if (level_mem[first + k] > th)
				b[k] = 1'b0;
		end
		return b;
	endfunction

	task automatic push_run(input logic [7:0] reg_no, input bit refresh, input logic [7:0] th);
		logic [6:0] addr;
		for (int e = 0; e < NUM_EXPANDERS; e++) begin
			addr = base_addr + 7'(e);
			bytes_due.push_back('{bus_byte: {addr, 1'b0}, start_before: 1'b1,
				stop_after: 1'b0, last: 1'b0});
			bytes_due.push_back('{bus_byte: reg_no, start_before: 1'b0,
				stop_after: 1'b0, last: 1'b0});
			bytes_due.push_back('{bus_byte: refresh ? pack_group(e * 16, th) : 8'h00,
				start_before: 1'b0, stop_after: 1'b0, last: 1'b0});
			bytes_due.push_back('{bus_byte: refresh ? pack_group(e * 16 + 8, th) : 8'h00,
				start_before: 1'b0, stop_after: 1'b1,
				last: (e == NUM_EXPANDERS - 1)});
		end
	endtask

	task automatic predict_bytes(input in_item_t it);
		case (it.kind)
			KIND_WRITE: begin
				level_mem[it.channel_index] = it.level;
			end
			KIND_REFRESH: begin
				push_run(out_reg, 1'b1, step_threshold[step_cnt]);
				step_cnt = (step_cnt == 5'(NUM_STEPS - 1)) ? 5'd0 : step_cnt + 5'd1;
			end
			KIND_SETUP: begin
				push_run(dir_reg, 1'b0, 8'h00);
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input logic [1:0] kind, input logic [5:0] ch, input logic [7:0] lvl);
		in_item_t it;
		it = '{kind: kind, channel_index: ch, level: lvl};
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_bytes(it);
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid = 1'b0;
		while (bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_BASE_ADDR: base_addr = val[6:0];
			REG_OUT_REG:   out_reg   = val;
			REG_DIR_REG:   dir_reg   = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// receiver side
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (bytes_due.size() == 0) begin
				errors++;
				$display("%0t unexpected transfer: expected none, actual %h", $time, out_data);
			end else begin
				due_byte = bytes_due.pop_front();
				if (out_data.bus_byte !== due_byte.bus_byte) begin
					errors++;
					$display("%0t bus_byte mismatch: expected %h, actual %h",
						$time, due_byte.bus_byte, out_data.bus_byte);
				end
				if (out_data.start_before !== due_byte.start_before) begin
					errors++;
					$display("%0t start_before mismatch: expected %b, actual %b",
						$time, due_byte.start_before, out_data.start_before);
				end
				if (out_data.stop_after !== due_byte.stop_after) begin
					errors++;
					$display("%0t stop_after mismatch: expected %b, actual %b",
						$time, due_byte.stop_after, out_data.stop_after);
				end
				if (out_data.last !== due_byte.last) begin
					errors++;
					$display("%0t last mismatch: expected %b, actual %b",
						$time, due_byte.last, out_data.last);
				end
			end
		end
	end

	task automatic test_reset_state;
		send_item(KIND_REFRESH, 6'd0, 8'h00);
		send_item(KIND_SETUP, 6'd0, 8'h00);
	endtask

	task automatic test_level_edges;
		// step 1 is current, threshold 0x0f
		send_item(KIND_WRITE, 6'd0, 8'hFF);
		send_item(KIND_WRITE, 6'd1, 8'h00);
		send_item(KIND_WRITE, 6'd7, 8'h10);
		send_item(KIND_WRITE, 6'd8, 8'h0F);
		send_item(KIND_WRITE, 6'd15, 8'h80);
		send_item(KIND_WRITE, 6'd31, 8'h01);
		send_item(KIND_WRITE, 6'd48, 8'hFF);
		send_item(KIND_WRITE, 6'd63, 8'hAA);
		send_item(KIND_IGNORED, 6'd0, 8'h00);
		send_item(KIND_IGNORED, 6'd63, 8'hFF);
		send_item(KIND_REFRESH, 6'd63, 8'hFF);
		send_item(KIND_SETUP, 6'd63, 8'hFF);
	endtask

	task automatic test_cfg_edges;
		drain();
		// base address wraps past 127 on later expanders
		set_reg(REG_BASE_ADDR, 8'hFF);
		set_reg(REG_OUT_REG, 8'hFF);
		set_reg(REG_DIR_REG, 8'hFF);
		send_item(KIND_REFRESH, 6'd0, 8'h00);
		send_item(KIND_SETUP, 6'd0, 8'h00);
		drain();
		set_reg(REG_BASE_ADDR, 8'h00);
		set_reg(REG_OUT_REG, 8'h00);
		set_reg(REG_DIR_REG, 8'h00);
		send_item(KIND_REFRESH, 6'd0, 8'h00);
		send_item(KIND_SETUP, 6'd0, 8'h00);
	endtask

	task automatic test_random_traffic(input int n, input int s_pct, input int r_pct);
		int         r;
		logic [7:0] lvl;
		drain();
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		set_reg(REG_BASE_ADDR, 8'($urandom_range(255)));
		set_reg(REG_OUT_REG, 8'($urandom_range(255)));
		set_reg(REG_DIR_REG, 8'($urandom_range(255)));
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if ($urandom_range(3) == 0)
				lvl = step_threshold[step_cnt] + 8'($urandom_range(2)) - 8'd1;
			else
				lvl = 8'($urandom_range(255));
			if (r < 50)
				send_item(KIND_WRITE, 6'($urandom_range(63)), lvl);
			else if (r < 80)
				send_item(KIND_REFRESH, 6'($urandom_range(63)), 8'($urandom_range(255)));
			else if (r < 92)
				send_item(KIND_SETUP, 6'($urandom_range(63)), 8'($urandom_range(255)));
			else
				send_item(KIND_IGNORED, 6'($urandom_range(63)), lvl);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_BASE_ADDR;
		cfg_data      = 8'h00;
		errors        = 0;
		send_idle_pct = 7;
		recv_idle_pct = 81;
		for (int i = 0; i < 64; i++)
			level_mem[i] = 8'h00;
		step_cnt  = 5'd0;
		base_addr = 7'h20;
		out_reg   = 8'h12;
		dir_reg   = 8'h00;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_level_edges();
		test_cfg_edges();
		test_random_traffic(135, 7, 81);
		test_random_traffic(135, 81, 7);
		test_random_traffic(135, 0, 0);
		drain();

		if (errors == 0)
			$display("PASS threshold_pwm_expander_refresh");
		else
			$display("FAIL threshold_pwm_expander_refresh");
		$finish;
	end

endmodule
